// ----- hdl/chbd_pkg.sv -----
package chbd_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 15;

    // accumulator: six 33-bit pair products plus one 32-bit center product
    localparam int ACC_W = 36;

    // tap structure
    localparam int PAIR_COUNT      = 6;
    localparam int FILTER_SPAN_DEF = 23;

    // register map
    localparam int REG_COUNT = 7;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER = REG_IDX_W'(6);

    // coefficient bank, index 0..5 pair coefficients, index 6 center
    typedef logic [REG_COUNT-1:0][COEF_W-1:0] coef_arr_t;

    // per-stage load strobes handed to each lane
    typedef struct packed {
        logic load;     // history shift, one transaction accepted
        logic en_pre;   // pre-add stage
        logic en_prod;  // multiply stage
        logic en_part;  // partial sum stage
    } ctl_t;

endpackage

// ----- hdl/complex_halfband_decimator.sv -----
// Complex half-band decimate-by-two filter.
// Input stream: each s_tdata transaction carries two consecutive complex
// samples (newer and older); every accepted transaction yields one filtered
// complex sample on m_tdata, rounded half up from Q1.15 and saturated.
// Coefficients (six symmetric pairs, outermost first, then the center tap)
// are written on cfg_we/cfg_index/cfg_data; the user must write them only
// while the stream is idle; the block does not enforce it. Indexes beyond
// the register list are ignored. Throughput: one transaction per clock
// unless m_tready stalls. The real and imaginary lanes each run seven
// multipliers in parallel, one per tap pair and the center. Each result is
// registered through history, pre-add, multiply, partial sum and output.
// Each stage holds its own valid bit and moves up whenever the stage after
// it is empty or moving, so bubbles close up under a stall and s_tready
// stays high until the pipeline is full behind a stalled m_tready.
// Reset clears the sample history, the coefficients and all valid bits.
module complex_halfband_decimator #(
    parameter int FILTER_SPAN = chbd_pkg::FILTER_SPAN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream, from bit 0: newer_re, newer_im, older_re, older_im
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [4*chbd_pkg::SAMPLE_W-1:0]   s_tdata,
    // master stream, from bit 0: out_re, out_im
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*chbd_pkg::SAMPLE_W-1:0]   m_tdata,
    // coefficient write port
    input  logic                              cfg_we,
    input  logic [chbd_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [chbd_pkg::COEF_W-1:0]       cfg_data
);
    import chbd_pkg::*;

    localparam int STAGES = 4;

    coef_arr_t                  coef_reg;
    logic [STAGES-1:0]          v_reg;
    logic [STAGES-1:0]          en;
    logic                       en_out;
    logic                       out_valid_reg;
    logic [2*SAMPLE_W-1:0]      out_data_reg;
    logic                       accept;
    ctl_t                       ctl;
    logic signed [SAMPLE_W-1:0] res_re;
    logic signed [SAMPLE_W-1:0] res_im;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we && ({1'b0, cfg_index} < (REG_IDX_W+1)'(REG_COUNT)))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // stage enables, from the output back to the input
    always_comb
    begin
        en_out = !out_valid_reg || m_tready;
        en[STAGES-1] = !v_reg[STAGES-1] || en_out;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];
    assign accept   = s_tvalid && en[0];

    assign ctl.load    = accept;
    assign ctl.en_pre  = en[1];
    assign ctl.en_prod = en[2];
    assign ctl.en_part = en[3];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (en_out)
            begin
                out_valid_reg <= v_reg[STAGES-1];
            end
        end
    end

    // real and imaginary lanes
    chbd_lane #(
        .FILTER_SPAN(FILTER_SPAN)
    ) u_lane_re (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .newer (s_tdata[SAMPLE_W-1:0]),
        .older (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .coef  (coef_reg),
        .result(res_re)
    );

    chbd_lane #(
        .FILTER_SPAN(FILTER_SPAN)
    ) u_lane_im (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .newer (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .older (s_tdata[4*SAMPLE_W-1:3*SAMPLE_W]),
        .coef  (coef_reg),
        .result(res_im)
    );

    // merge both lanes into the output register
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_data_reg <= {res_im, res_re};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hdl/chbd_lane.sv -----
module chbd_lane #(
    parameter int FILTER_SPAN = chbd_pkg::FILTER_SPAN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  chbd_pkg::ctl_t                        ctl,
    input  logic signed [chbd_pkg::SAMPLE_W-1:0]  newer,
    input  logic signed [chbd_pkg::SAMPLE_W-1:0]  older,
    input  chbd_pkg::coef_arr_t                   coef,
    output logic signed [chbd_pkg::SAMPLE_W-1:0]  result
);
    import chbd_pkg::*;

    localparam int HIST_LEN = FILTER_SPAN + 1;
    localparam int MID      = FILTER_SPAN / 2 + 1;
    localparam int PRE_W    = SAMPLE_W + 1;
    localparam int PROD_W   = PRE_W + COEF_W;
    localparam int Q_W      = ACC_W - FRAC_W;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [Q_W-1:0]   SAT_MAX  = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_MIN  = -Q_W'(1 << (SAMPLE_W - 1));

    logic signed [SAMPLE_W-1:0] hist_reg [HIST_LEN];
    logic signed [SAMPLE_W-1:0] tap_a [PAIR_COUNT];
    logic signed [SAMPLE_W-1:0] tap_b [PAIR_COUNT];
    logic signed [PRE_W-1:0]    pre_reg [PAIR_COUNT];
    logic signed [SAMPLE_W-1:0] center_reg;
    logic signed [PROD_W-1:0]   prod_reg [PAIR_COUNT+1];
    logic signed [ACC_W-1:0]    part_a_reg;
    logic signed [ACC_W-1:0]    part_b_reg;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [Q_W-1:0]      q;

    // sample history, two samples in per transaction, newest at index 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_LEN; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctl.load)
        begin
            hist_reg[0] <= newer;
            hist_reg[1] <= older;
            for (int i = 2; i < HIST_LEN; i++)
            begin
                hist_reg[i] <= hist_reg[i-2];
            end
        end
    end

    // tap selection; taps that fall outside the history read as zero
    for (genvar k = 0; k < PAIR_COUNT; k++)
    begin : g_tap
        localparam int DA = 2 * k + 1;
        localparam int DB = FILTER_SPAN - 2 * k;
        if (DA < HIST_LEN)
        begin : g_a_in
            assign tap_a[k] = hist_reg[DA];
        end
        else
        begin : g_a_out
            assign tap_a[k] = '0;
        end
        if (DB >= 0 && DB < HIST_LEN)
        begin : g_b_in
            assign tap_b[k] = hist_reg[DB];
        end
        else
        begin : g_b_out
            assign tap_b[k] = '0;
        end
    end

    // symmetric pre-add
    always_ff @(posedge clk)
    begin
        if (ctl.en_pre)
        begin
            for (int k = 0; k < PAIR_COUNT; k++)
            begin
                pre_reg[k] <= PRE_W'(tap_a[k]) + PRE_W'(tap_b[k]);
            end
            center_reg <= hist_reg[MID];
        end
    end

    // one multiplier per pair plus the center
    always_ff @(posedge clk)
    begin
        if (ctl.en_prod)
        begin
            for (int k = 0; k < PAIR_COUNT; k++)
            begin
                prod_reg[k] <= pre_reg[k] * $signed(coef[k]);
            end
            prod_reg[PAIR_COUNT] <= PROD_W'(center_reg * $signed(coef[REG_CENTER]));
        end
    end

    // two partial sums
    always_ff @(posedge clk)
    begin
        if (ctl.en_part)
        begin
            part_a_reg <= ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) + ACC_W'(prod_reg[2]);
            part_b_reg <= ACC_W'(prod_reg[3]) + ACC_W'(prod_reg[4]) + ACC_W'(prod_reg[5])
                        + ACC_W'(prod_reg[PAIR_COUNT]);
        end
    end

    // final add, round half up, saturate
    always_comb
    begin
        acc = part_a_reg + part_b_reg;
        rnd = acc + HALF_LSB;
        q   = rnd[ACC_W-1:FRAC_W];
        if (q > SAT_MAX)
        begin
            result = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (q < SAT_MIN)
        begin
            result = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            result = q[SAMPLE_W-1:0];
        end
    end

endmodule

// ----- dv/complex_halfband_decimator_tb.sv -----
`timescale 1ns / 1ps

module complex_halfband_decimator_tb;
    import chbd_pkg::*;

    localparam int SPAN           = FILTER_SPAN_DEF;
    localparam int HIST_DEPTH     = SPAN + 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(REG_COUNT);

    // one input transaction, packed as on s_tdata (newer_re in the low bits)
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] older_im;
        logic signed [SAMPLE_W-1:0] older_re;
        logic signed [SAMPLE_W-1:0] newer_im;
        logic signed [SAMPLE_W-1:0] newer_re;
    } pair_item_t;

    // one complex sample, packed as on m_tdata (re in the low bits)
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] im;
        logic signed [SAMPLE_W-1:0] re;
    } iq_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [4*SAMPLE_W-1:0]         s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [2*SAMPLE_W-1:0]         m_tdata;
    logic                          cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]          cfg_index = '0;
    logic [COEF_W-1:0]             cfg_data = '0;

    // filter state mirrored by the predictor
    iq_t                           history [HIST_DEPTH];
    logic signed [COEF_W-1:0]      coef_bank [REG_COUNT];
    logic signed [COEF_W-1:0]      coef_plan [REG_COUNT];

    pair_item_t                    pending_pairs [$];
    iq_t                           expected_out [$];

    // handshake and idling control
    logic                          s_took = 1'b0;
    bit                            hold_sender = 1'b0;
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;
    int                            quiet_cycles = 0;
    int                            fail_count = 0;
    int                            pairs_accepted = 0;
    int                            outputs_checked = 0;
    int                            coef_sets = 0;

    complex_halfband_decimator #(
        .FILTER_SPAN(SPAN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // taps outside the history read as zero
    function automatic iq_t history_at(input int delay);
        if (delay < 0 || delay >= HIST_DEPTH)
            return '0;
        return history[delay];
    endfunction

    // round half up from Q1.15, then clip to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return SAMPLE_W'(q);
    endfunction

    // shift in one sample pair and compute the decimated output
    function automatic iq_t decimate_step(input pair_item_t item);
        longint acc_re;
        longint acc_im;
        iq_t    a;
        iq_t    b;
        iq_t    result;
        for (int i = HIST_DEPTH - 1; i >= 2; i--)
            history[i] = history[i-2];
        history[0].re = item.newer_re;
        history[0].im = item.newer_im;
        history[1].re = item.older_re;
        history[1].im = item.older_im;
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < PAIR_COUNT; k++)
        begin
            a = history_at(2 * k + 1);
            b = history_at(SPAN - 2 * k);
            acc_re += (longint'($signed(a.re)) + longint'($signed(b.re)))
                      * longint'($signed(coef_bank[k]));
            acc_im += (longint'($signed(a.im)) + longint'($signed(b.im)))
                      * longint'($signed(coef_bank[k]));
        end
        a = history_at(SPAN / 2 + 1);
        acc_re += longint'($signed(a.re)) * longint'($signed(coef_bank[REG_CENTER]));
        acc_im += longint'($signed(a.im)) * longint'($signed(coef_bank[REG_CENTER]));
        result.re = round_clip(acc_re);
        result.im = round_clip(acc_im);
        return result;
    endfunction

    // sample value biased toward the extremes and small numbers
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random_pairs(input int count);
        pair_item_t item;
        for (int n = 0; n < count; n++)
        begin
            item.newer_re = rand_sample();
            item.newer_im = rand_sample();
            item.older_re = rand_sample();
            item.older_im = rand_sample();
            pending_pairs.push_back(item);
        end
    endtask

    // write the planned coefficients, plus one write past the register list
    task automatic apply_coef_plan();
        for (int r = 0; r < REG_COUNT; r++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= REG_IDX_W'(r);
            cfg_data  <= coef_plan[r];
            coef_bank[r] = coef_plan[r];
        end
        @(negedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= 16'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        coef_sets++;
    endtask

    // wait until the stream is empty, then let the pipeline settle;
    // checked at the rising edge so the sender's last update is visible
    task automatic drain_pipeline();
        do
            @(posedge clk);
        while (pending_pairs.size() != 0 || s_tvalid || expected_out.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender: hold each transaction until accepted, random gaps between
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_took)
        begin
            if (!hold_sender && pending_pairs.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tdata  <= pending_pairs.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // input side: predict on every accepted transaction
    always @(posedge clk)
    begin
        s_took <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_out.push_back(decimate_step(pair_item_t'(s_tdata)));
            pairs_accepted++;
        end
    end

    // output side: compare against the oldest prediction
    always @(posedge clk)
    begin
        iq_t got;
        iq_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = iq_t'(m_tdata);
            if (expected_out.size() == 0)
            begin
                $error("unexpected output transaction: re %0d im %0d",
                       $signed(got.re), $signed(got.im));
                fail_count++;
            end
            else
            begin
                want = expected_out.pop_front();
                if (got.re !== want.re)
                begin
                    $error("out_re mismatch: expected %0d, got %0d",
                           $signed(want.re), $signed(got.re));
                    fail_count++;
                end
                if (got.im !== want.im)
                begin
                    $error("out_im mismatch: expected %0d, got %0d",
                           $signed(want.im), $signed(got.im));
                    fail_count++;
                end
                outputs_checked++;
            end
        end
    end

    // watchdog on cycles with no traffic on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        pair_item_t item;
        logic signed [SAMPLE_W-1:0] round_vals [12];

        round_vals = '{16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sd32767, -16'sd32768,
                       16'sd0, 16'sd7, -16'sd7, 16'sd1, -16'sd1, 16'sd2};
        foreach (history[i])
            history[i] = '0;
        foreach (coef_bank[i])
            coef_bank[i] = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rounding: center at one half, outermost pair at full negative scale
        foreach (coef_plan[i])
            coef_plan[i] = '0;
        coef_plan[0]          = -16'sd32768;
        coef_plan[REG_CENTER] = 16'sd16384;
        apply_coef_plan();
        for (int i = 0; i < 12; i++)
        begin
            item.newer_re = round_vals[i];
            item.newer_im = -round_vals[i];
            item.older_re = round_vals[i];
            item.older_im = 16'(i);
            pending_pairs.push_back(item);
        end
        drain_pipeline();

        // saturation both ways: every coefficient at full positive scale
        foreach (coef_plan[i])
            coef_plan[i] = 16'sd32767;
        apply_coef_plan();
        for (int i = 0; i < 12; i++)
        begin
            item = (i < 6) ? {4{16'h7fff}} : {4{16'h8000}};
            pending_pairs.push_back(item);
        end

        // random phases, one idling mix and one coefficient style each
        for (int mode = 0; mode < 4; mode++)
        begin
            drain_pipeline();
            foreach (coef_plan[i])
            begin
                case (mode)
                    0: coef_plan[i] = 16'($urandom);
                    2: coef_plan[i] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                    default: coef_plan[i] = $signed(16'($urandom)) >>> 3;
                endcase
            end
            apply_coef_plan();
            send_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 29 : 0;
            stall_pct     = (mode == 2) ? 45 : (mode == 3) ? 29 : 0;
            queue_random_pairs(50);

            // sender holds off until every output of the first half is back
            while (pending_pairs.size() != 0)
                @(negedge clk);
            hold_sender = 1'b1;
            do
                @(posedge clk);
            while (s_tvalid || expected_out.size() != 0);
            hold_sender = 1'b0;
            queue_random_pairs(50);
        end

        drain_pipeline();
        $display("Covered %0d input pairs and %0d checked outputs over %0d coefficient sets,",
                 pairs_accepted, outputs_checked, coef_sets);
        $display("with rounding, saturation and idle/stall mixes up to 45 percent.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
